@@ rtl/core/assert_macros.svh @@
// assertion helpers for the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition that must hold at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// antecedent in one cycle implies consequent in the next
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/core/epsd_pkg.sv @@
package epsd_pkg;

   // result status codes
   localparam logic [1:0] STATUS_IDLE    = 2'd0;
   localparam logic [1:0] STATUS_MOVING  = 2'd1;
   localparam logic [1:0] STATUS_REACHED = 2'd2;
   localparam logic [1:0] STATUS_STALLED = 2'd3;

   // item kinds
   localparam logic KIND_SAMPLE = 1'b0;
   localparam logic KIND_START  = 1'b1;

   // register map, word index
   localparam int unsigned CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] REG_DRIVE_SPEED      = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_DRIVE_INVERT     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_STALL_WINDOW_MS  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] REG_STALL_MIN_COUNTS = 2'd3;

   // register reset values
   localparam logic [7:0]  DRIVE_SPEED_RST      = 8'd50;
   localparam logic        DRIVE_INVERT_RST     = 1'b0;
   localparam logic [10:0] STALL_WINDOW_MS_RST  = 11'd1000;
   localparam logic [7:0]  STALL_MIN_COUNTS_RST = 8'd2;

   // millisecond timer saturation
   localparam logic [10:0] MS_MAX = 11'd2047;

   // encoder phase values
   localparam logic signed [3:0] PH_ZERO = 4'sd0;
   localparam logic signed [3:0] PH_P1   = 4'sd1;
   localparam logic signed [3:0] PH_P2   = 4'sd2;
   localparam logic signed [3:0] PH_P3   = 4'sd3;
   localparam logic signed [3:0] PH_P4   = 4'sd4;
   localparam logic signed [3:0] PH_N1   = -4'sd1;
   localparam logic signed [3:0] PH_N2   = -4'sd2;
   localparam logic signed [3:0] PH_N3   = -4'sd3;
   localparam logic signed [3:0] PH_N4   = -4'sd4;

   // encoder channel levels {left, right}
   localparam logic [1:0] ENC_NONE  = 2'b00;
   localparam logic [1:0] ENC_RIGHT = 2'b01;
   localparam logic [1:0] ENC_LEFT  = 2'b10;
   localparam logic [1:0] ENC_BOTH  = 2'b11;

   typedef struct packed {
      logic [7:0]  drive_speed;
      logic        drive_invert;
      logic [10:0] stall_window_ms;
      logic [7:0]  stall_min_counts;
   } cfg_type;

   typedef struct packed {
      logic               kind;
      logic               enc_left;
      logic               enc_right;
      logic               ms_tick;
      logic signed [15:0] target;
   } item_type;

   typedef struct packed {
      logic signed [8:0]  drive;
      logic [1:0]         status;
      logic signed [15:0] position;
   } rsp_type;

endpackage

@@ rtl/core/encoder_positioner_stall_detect_unit.sv @@
// channel   | role                          | handshake
// ----------+-------------------------------+-------------------------------
// req_*     | encoder sample or start word  | tvalid/tready, kind in tuser
// rsp_*     | drive, status, position word  | tvalid/tready
// csr_*     | four control registers        | apb style, pready tied high
//
// one word in per cycle while rsp is not stalled, one word out per word in;
// each word passes the input register, then the result register, with the
// single compute stage between them. the motion state updates as a word
// leaves the input register, so the next word sees it at once.
// reset is synchronous, active high; clears registers, motion state and both
// stages. a stalled rsp side holds the result register and backs up into req.
module encoder_positioner_stall_detect_unit #(
   parameter int POS_WIDTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   // req side
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // enc_left[0], enc_right[1], ms_tick[2], target[18:3], 0
   input  logic        req_tuser,   // kind[0]
   // rsp side
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // drive[8:0], status[10:9], position[26:11], 0
   // register port
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

`include "assert_macros.svh"

   // registers
   epsd_pkg::cfg_type cfg_ff;
   epsd_pkg::cfg_type cfg_in;

   // input stage
   logic                 stage_valid_ff, stage_valid_in;
   epsd_pkg::item_type   stage_item_ff, stage_item_in;

   // result stage
   logic                 out_valid_ff, out_valid_in;
   epsd_pkg::rsp_type    out_rsp_ff, out_rsp_in;

   // motion state
   logic signed [3:0]           phase_ff, phase_in;
   logic signed [POS_WIDTH-1:0] count_ff, count_in;
   logic signed [POS_WIDTH-1:0] check_count_ff, check_count_in;
   logic [10:0]                 elapsed_ms_ff, elapsed_ms_in;
   logic signed [15:0]          goal_ff, goal_in;
   logic                        moving_down_ff, moving_down_in;
   logic                        busy_ff, busy_in;

   epsd_pkg::rsp_type           calc_rsp;
   logic signed [3:0]           calc_phase;
   logic signed [POS_WIDTH-1:0] calc_count;
   logic signed [POS_WIDTH-1:0] calc_check_count;
   logic [10:0]                 calc_elapsed_ms;
   logic signed [15:0]          calc_goal;
   logic                        calc_moving_down;
   logic                        calc_busy;

   logic                           advance;
   logic                           req_take;
   logic                           csr_write;
   logic [epsd_pkg::CSR_IDX_W-1:0] csr_idx;

   // stage moves on when the result register is free or being emptied
   assign advance    = stage_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !stage_valid_ff || advance;
   assign req_take   = req_tvalid && req_tready;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_idx    = csr_paddr[3:2];

   // register write
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (csr_idx)
            epsd_pkg::REG_DRIVE_SPEED:      cfg_in.drive_speed      = csr_pwdata[7:0];
            epsd_pkg::REG_DRIVE_INVERT:     cfg_in.drive_invert     = csr_pwdata[0];
            epsd_pkg::REG_STALL_WINDOW_MS:  cfg_in.stall_window_ms  = csr_pwdata[10:0];
            epsd_pkg::REG_STALL_MIN_COUNTS: cfg_in.stall_min_counts = csr_pwdata[7:0];
            default:                        cfg_in = cfg_ff;
         endcase
      end
   end

   // register read
   always_comb begin
      unique case (csr_idx)
         epsd_pkg::REG_DRIVE_SPEED:      csr_prdata = {24'd0, cfg_ff.drive_speed};
         epsd_pkg::REG_DRIVE_INVERT:     csr_prdata = {31'd0, cfg_ff.drive_invert};
         epsd_pkg::REG_STALL_WINDOW_MS:  csr_prdata = {21'd0, cfg_ff.stall_window_ms};
         epsd_pkg::REG_STALL_MIN_COUNTS: csr_prdata = {24'd0, cfg_ff.stall_min_counts};
         default:                        csr_prdata = 32'd0;
      endcase
   end

   // unpack the incoming word
   always_comb begin
      stage_valid_in = stage_valid_ff;
      stage_item_in  = stage_item_ff;
      if (advance) begin
         stage_valid_in = 1'b0;
      end
      if (req_take) begin
         stage_valid_in          = 1'b1;
         stage_item_in.kind      = req_tuser;
         stage_item_in.enc_left  = req_tdata[0];
         stage_item_in.enc_right = req_tdata[1];
         stage_item_in.ms_tick   = req_tdata[2];
         stage_item_in.target    = req_tdata[18:3];
      end
   end

   epsd_calc #(
      .POS_WIDTH (POS_WIDTH)
   ) u_calc (
      .cfg            (cfg_ff),
      .item           (stage_item_ff),
      .phase          (phase_ff),
      .count          (count_ff),
      .check_count    (check_count_ff),
      .elapsed_ms     (elapsed_ms_ff),
      .goal           (goal_ff),
      .moving_down    (moving_down_ff),
      .busy           (busy_ff),
      .phase_in       (calc_phase),
      .count_in       (calc_count),
      .check_count_in (calc_check_count),
      .elapsed_ms_in  (calc_elapsed_ms),
      .goal_in        (calc_goal),
      .moving_down_in (calc_moving_down),
      .busy_in        (calc_busy),
      .rsp            (calc_rsp)
   );

   // motion state commits only as the word leaves the input stage
   always_comb begin
      phase_in       = phase_ff;
      count_in       = count_ff;
      check_count_in = check_count_ff;
      elapsed_ms_in  = elapsed_ms_ff;
      goal_in        = goal_ff;
      moving_down_in = moving_down_ff;
      busy_in        = busy_ff;
      if (advance) begin
         phase_in       = calc_phase;
         count_in       = calc_count;
         check_count_in = calc_check_count;
         elapsed_ms_in  = calc_elapsed_ms;
         goal_in        = calc_goal;
         moving_down_in = calc_moving_down;
         busy_in        = calc_busy;
      end
   end

   // result register
   always_comb begin
      out_valid_in = out_valid_ff;
      out_rsp_in   = out_rsp_ff;
      if (out_valid_ff && rsp_tready) begin
         out_valid_in = 1'b0;
      end
      if (advance) begin
         out_valid_in = 1'b1;
         out_rsp_in   = calc_rsp;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.drive_speed      <= epsd_pkg::DRIVE_SPEED_RST;
         cfg_ff.drive_invert     <= epsd_pkg::DRIVE_INVERT_RST;
         cfg_ff.stall_window_ms  <= epsd_pkg::STALL_WINDOW_MS_RST;
         cfg_ff.stall_min_counts <= epsd_pkg::STALL_MIN_COUNTS_RST;
         stage_valid_ff          <= 1'b0;
         out_valid_ff            <= 1'b0;
         phase_ff                <= epsd_pkg::PH_ZERO;
         count_ff                <= '0;
         check_count_ff          <= '0;
         elapsed_ms_ff           <= 11'd0;
         goal_ff                 <= 16'sd0;
         moving_down_ff          <= 1'b0;
         busy_ff                 <= 1'b0;
      end else begin
         cfg_ff         <= cfg_in;
         stage_valid_ff <= stage_valid_in;
         out_valid_ff   <= out_valid_in;
         phase_ff       <= phase_in;
         count_ff       <= count_in;
         check_count_ff <= check_count_in;
         elapsed_ms_ff  <= elapsed_ms_in;
         goal_ff        <= goal_in;
         moving_down_ff <= moving_down_in;
         busy_ff        <= busy_in;
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      stage_item_ff <= stage_item_in;
      out_rsp_ff    <= out_rsp_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {5'd0, out_rsp_ff.position, out_rsp_ff.status, out_rsp_ff.drive};

   // checks
   `ASSERT_ALWAYS(a_drive_only_moving, clock, reset, !out_valid_ff || (out_rsp_ff.status == epsd_pkg::STATUS_MOVING) || (out_rsp_ff.drive == 9'sd0), "drive nonzero outside a move")
   `ASSERT_NEXT(a_end_clears_busy, clock, reset, advance && ((calc_rsp.status == epsd_pkg::STATUS_REACHED) || (calc_rsp.status == epsd_pkg::STATUS_STALLED)), !busy_ff, "move ended but still busy")
   `ASSERT_NEXT(a_start_arms_window, clock, reset, advance && (stage_item_ff.kind == epsd_pkg::KIND_START) && (calc_rsp.status == epsd_pkg::STATUS_MOVING), busy_ff && (elapsed_ms_ff == 11'd0) && (check_count_ff == count_ff), "start did not restart stall window")
   `ASSERT_ALWAYS(a_phase_range, clock, reset, (phase_ff <= epsd_pkg::PH_P4) && (phase_ff >= epsd_pkg::PH_N4), "encoder phase out of range")

endmodule

@@ rtl/core/epsd_calc.sv @@
module epsd_calc #(
   parameter int POS_WIDTH = 16
) (
   input  epsd_pkg::cfg_type              cfg,
   input  epsd_pkg::item_type             item,
   input  logic signed [3:0]              phase,
   input  logic signed [POS_WIDTH-1:0]    count,
   input  logic signed [POS_WIDTH-1:0]    check_count,
   input  logic [10:0]                    elapsed_ms,
   input  logic signed [15:0]             goal,
   input  logic                           moving_down,
   input  logic                           busy,
   output logic signed [3:0]              phase_in,
   output logic signed [POS_WIDTH-1:0]    count_in,
   output logic signed [POS_WIDTH-1:0]    check_count_in,
   output logic [10:0]                    elapsed_ms_in,
   output logic signed [15:0]             goal_in,
   output logic                           moving_down_in,
   output logic                           busy_in,
   output epsd_pkg::rsp_type              rsp
);

   // common compare width, one bit beyond both count and goal
   localparam int EW = ((POS_WIDTH > 16) ? POS_WIDTH : 16) + 1;

   localparam logic signed [POS_WIDTH-1:0] CNT_MAX = {1'b0, {(POS_WIDTH-1){1'b1}}};
   localparam logic signed [POS_WIDTH-1:0] CNT_MIN = {1'b1, {(POS_WIDTH-1){1'b0}}};
   localparam logic signed [EW-1:0] POS_HI = EW'(32'sd32767);
   localparam logic signed [EW-1:0] POS_LO = EW'(-32'sd32768);

   function automatic logic signed [3:0] phase_next(input logic signed [3:0] p,
                                                    input logic [1:0] c);
      logic signed [3:0] n;
      n = epsd_pkg::PH_ZERO;
      case (p)
         epsd_pkg::PH_ZERO: n = (c == epsd_pkg::ENC_LEFT) ? epsd_pkg::PH_P1 :
                                (c == epsd_pkg::ENC_RIGHT) ? epsd_pkg::PH_N1 : epsd_pkg::PH_ZERO;
         epsd_pkg::PH_P1:   n = (c == epsd_pkg::ENC_BOTH) ? epsd_pkg::PH_P2 :
                                (c == epsd_pkg::ENC_NONE) ? epsd_pkg::PH_ZERO : epsd_pkg::PH_P1;
         epsd_pkg::PH_P2:   n = (c == epsd_pkg::ENC_RIGHT) ? epsd_pkg::PH_P3 :
                                (c == epsd_pkg::ENC_LEFT) ? epsd_pkg::PH_P1 : epsd_pkg::PH_P2;
         epsd_pkg::PH_P3:   n = (c == epsd_pkg::ENC_NONE) ? epsd_pkg::PH_P4 :
                                (c == epsd_pkg::ENC_BOTH) ? epsd_pkg::PH_P2 : epsd_pkg::PH_P3;
         epsd_pkg::PH_N1:   n = (c == epsd_pkg::ENC_NONE) ? epsd_pkg::PH_ZERO :
                                (c == epsd_pkg::ENC_BOTH) ? epsd_pkg::PH_N2 : epsd_pkg::PH_N1;
         epsd_pkg::PH_N2:   n = (c == epsd_pkg::ENC_RIGHT) ? epsd_pkg::PH_N1 :
                                (c == epsd_pkg::ENC_LEFT) ? epsd_pkg::PH_N3 : epsd_pkg::PH_N2;
         epsd_pkg::PH_N3:   n = (c == epsd_pkg::ENC_BOTH) ? epsd_pkg::PH_N2 :
                                (c == epsd_pkg::ENC_NONE) ? epsd_pkg::PH_N4 : epsd_pkg::PH_N3;
         default:           n = epsd_pkg::PH_ZERO;
      endcase
      return n;
   endfunction

   function automatic logic signed [8:0] drive_of(input logic down,
                                                  input epsd_pkg::cfg_type c);
      logic signed [8:0] mag;
      mag = {1'b0, c.drive_speed};
      return ((!down) ^ c.drive_invert) ? -mag : mag;
   endfunction

   logic signed [EW-1:0]        count_x;
   logic signed [EW-1:0]        target_x;
   logic signed [EW-1:0]        goal_x;
   logic signed [EW-1:0]        count_new_x;
   logic signed [POS_WIDTH-1:0] count_step;
   logic signed [POS_WIDTH-1:0] count_next;
   logic                        step_en;
   logic [10:0]                 elapsed_next;
   logic signed [POS_WIDTH:0]   moved;
   logic [POS_WIDTH:0]          moved_abs;
   logic                        stalled;
   logic                        at_goal;

   assign count_x     = {{(EW-POS_WIDTH){count[POS_WIDTH-1]}}, count};
   assign target_x    = {{(EW-16){item.target[15]}}, item.target};
   assign goal_x      = {{(EW-16){goal[15]}}, goal};
   assign count_new_x = {{(EW-POS_WIDTH){count_next[POS_WIDTH-1]}}, count_next};

   // distance moved since the last stall check
   assign moved     = {count[POS_WIDTH-1], count} - {check_count[POS_WIDTH-1], check_count};
   assign moved_abs = moved[POS_WIDTH] ? (POS_WIDTH+1)'(-moved) : (POS_WIDTH+1)'(moved);

   assign elapsed_next = (item.ms_tick && (elapsed_ms != epsd_pkg::MS_MAX)) ?
                         elapsed_ms + 11'd1 : elapsed_ms;

   assign stalled = (elapsed_next > cfg.stall_window_ms) &&
                    (moved_abs < (POS_WIDTH+1)'(cfg.stall_min_counts));

   // count bump from a full phase, saturating at the count limits
   assign count_step = ((phase == epsd_pkg::PH_P4) && (count != CNT_MAX)) ? count + POS_WIDTH'(1) :
                       ((phase == epsd_pkg::PH_N4) && (count != CNT_MIN)) ? count - POS_WIDTH'(1) :
                       count;
   assign step_en    = (item.kind == epsd_pkg::KIND_SAMPLE) && busy && !stalled;
   assign count_next = step_en ? count_step : count;

   assign at_goal = moving_down ? !(goal_x < count_new_x) : !(goal_x > count_new_x);

   always_comb begin
      phase_in       = phase;
      count_in       = count_next;
      check_count_in = check_count;
      elapsed_ms_in  = elapsed_ms;
      goal_in        = goal;
      moving_down_in = moving_down;
      busy_in        = busy;
      rsp.drive      = 9'sd0;
      rsp.status     = epsd_pkg::STATUS_IDLE;

      if (item.kind == epsd_pkg::KIND_START) begin
         goal_in        = item.target;
         moving_down_in = target_x < count_x;
         if (target_x == count_x) begin
            // already there
            busy_in    = 1'b0;
            rsp.status = epsd_pkg::STATUS_REACHED;
         end else begin
            busy_in        = 1'b1;
            check_count_in = count;
            elapsed_ms_in  = 11'd0;
            rsp.drive      = drive_of(target_x < count_x, cfg);
            rsp.status     = epsd_pkg::STATUS_MOVING;
         end
      end else if (busy) begin
         elapsed_ms_in = elapsed_next;
         if ((elapsed_next > cfg.stall_window_ms) && !stalled) begin
            check_count_in = count;
            elapsed_ms_in  = 11'd0;
         end
         if (stalled) begin
            busy_in    = 1'b0;
            rsp.status = epsd_pkg::STATUS_STALLED;
         end else begin
            phase_in   = phase_next(phase, {item.enc_left, item.enc_right});
            rsp.drive  = drive_of(moving_down, cfg);
            rsp.status = epsd_pkg::STATUS_MOVING;
            if (at_goal) begin
               busy_in    = 1'b0;
               rsp.drive  = 9'sd0;
               rsp.status = epsd_pkg::STATUS_REACHED;
            end
         end
      end

      // position clamps to the 16-bit report range
      if (count_new_x > POS_HI) begin
         rsp.position = 16'sh7FFF;
      end else if (count_new_x < POS_LO) begin
         rsp.position = 16'sh8000;
      end else begin
         rsp.position = count_new_x[15:0];
      end
   end

endmodule

@@ tb/epsd_motion_checker.sv @@
module epsd_motion_checker
   import epsd_pkg::*;
#(
   parameter int POS_WIDTH = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   input  logic               req_tready,
   input  logic [23:0]        req_tdata,
   input  logic               req_tuser,
   input  logic               rsp_tvalid,
   input  logic               rsp_tready,
   input  logic [31:0]        rsp_tdata,
   input  logic               csr_psel,
   input  logic               csr_penable,
   input  logic               csr_pwrite,
   input  logic               csr_pready,
   input  logic [3:0]         csr_paddr,
   input  logic [31:0]        csr_pwdata,
   output int                 error_count,
   output int                 pending,
   output int                 n_checked,
   output int                 n_reached,
   output int                 n_stalled,
   output logic signed [15:0] model_pos,
   output logic               model_busy
);

   localparam longint POS_MAX = (longint'(1) <<< (POS_WIDTH - 1)) - 1;
   localparam longint POS_MIN = -POS_MAX - 1;

   // shadow of the control registers, tracked from the register bus
   cfg_type cfg;

   // motion state
   logic signed [3:0] phase_q;
   longint            count_q;
   longint            check_q;
   longint            goal_q;
   logic [10:0]       elapsed_q;
   logic              down_q;
   logic              busy_q;

   rsp_type want_q[$];

   function automatic logic signed [8:0] move_drive(cfg_type c, logic down);
      logic signed [8:0] d;
      d = $signed({1'b0, c.drive_speed});
      if (!down) d = -d;
      if (c.drive_invert) d = -d;
      return d;
   endfunction

   function automatic logic goal_met(longint g, longint c, logic down);
      return down ? !(g < c) : !(g > c);
   endfunction

   function automatic logic signed [15:0] clamp_pos(longint c);
      if (c > 32767) return 16'sh7fff;
      if (c < -32768) return -16'sh8000;
      return c[15:0];
   endfunction

   task automatic report_mismatch(input string what, input longint got_v, input longint want_v);
      $display("%0t: mismatch on %s: got %0d, expected %0d (result %0d)",
               $time, what, got_v, want_v, n_checked);
      error_count++;
   endtask

   task automatic advance_positioner(input item_type it, output rsp_type r);
      logic signed [15:0] tgt;
      longint             moved;
      logic               stalled;
      logic [1:0]         lvl;
      r.drive  = '0;
      r.status = STATUS_IDLE;
      if (it.kind == KIND_START) begin
         tgt = it.target;
         goal_q = tgt;
         down_q = goal_q < count_q;
         if (goal_met(goal_q, count_q, down_q)) begin
            busy_q   = 1'b0;
            r.status = STATUS_REACHED;
         end else begin
            busy_q    = 1'b1;
            check_q   = count_q;
            elapsed_q = '0;
            r.drive   = move_drive(cfg, down_q);
            r.status  = STATUS_MOVING;
         end
      end else if (busy_q) begin
         stalled = 1'b0;
         if (it.ms_tick && elapsed_q < MS_MAX) elapsed_q++;
         if (elapsed_q > cfg.stall_window_ms) begin
            moved = count_q - check_q;
            if (moved < 0) moved = -moved;
            if (moved < cfg.stall_min_counts) begin
               stalled = 1'b1;
            end else begin
               check_q   = count_q;
               elapsed_q = '0;
            end
         end
         if (stalled) begin
            busy_q   = 1'b0;
            r.status = STATUS_STALLED;
         end else begin
            lvl = {it.enc_left, it.enc_right};
            case (phase_q)
               PH_ZERO: phase_q = (lvl == ENC_LEFT) ? PH_P1 : (lvl == ENC_RIGHT) ? PH_N1 : PH_ZERO;
               PH_P1:   phase_q = (lvl == ENC_BOTH) ? PH_P2 : (lvl == ENC_NONE) ? PH_ZERO : PH_P1;
               PH_P2:   phase_q = (lvl == ENC_RIGHT) ? PH_P3 : (lvl == ENC_LEFT) ? PH_P1 : PH_P2;
               PH_P3:   phase_q = (lvl == ENC_NONE) ? PH_P4 : (lvl == ENC_BOTH) ? PH_P2 : PH_P3;
               PH_N1:   phase_q = (lvl == ENC_NONE) ? PH_ZERO : (lvl == ENC_BOTH) ? PH_N2 : PH_N1;
               PH_N2:   phase_q = (lvl == ENC_RIGHT) ? PH_N1 : (lvl == ENC_LEFT) ? PH_N3 : PH_N2;
               PH_N3:   phase_q = (lvl == ENC_BOTH) ? PH_N2 : (lvl == ENC_NONE) ? PH_N4 : PH_N3;
               PH_P4: begin
                  if (count_q < POS_MAX) count_q++;
                  phase_q = PH_ZERO;
               end
               PH_N4: begin
                  if (count_q > POS_MIN) count_q--;
                  phase_q = PH_ZERO;
               end
               default: phase_q = PH_ZERO;
            endcase
            r.drive  = move_drive(cfg, down_q);
            r.status = STATUS_MOVING;
            if (goal_met(goal_q, count_q, down_q)) begin
               busy_q   = 1'b0;
               r.drive  = '0;
               r.status = STATUS_REACHED;
            end
         end
      end
      r.position = clamp_pos(count_q);
   endtask

   always @(posedge clock) begin : watch
      item_type it;
      rsp_type  got;
      rsp_type  want;
      rsp_type  next_r;
      if (reset) begin
         cfg.drive_speed      = DRIVE_SPEED_RST;
         cfg.drive_invert     = DRIVE_INVERT_RST;
         cfg.stall_window_ms  = STALL_WINDOW_MS_RST;
         cfg.stall_min_counts = STALL_MIN_COUNTS_RST;
         phase_q   = PH_ZERO;
         count_q   = 0;
         check_q   = 0;
         goal_q    = 0;
         elapsed_q = '0;
         down_q    = 1'b0;
         busy_q    = 1'b0;
         want_q.delete();
         error_count = 0;
         n_checked   = 0;
         n_reached   = 0;
         n_stalled   = 0;
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_paddr[CSR_IDX_W+1:2])
               REG_DRIVE_SPEED:      cfg.drive_speed      = csr_pwdata[7:0];
               REG_DRIVE_INVERT:     cfg.drive_invert     = csr_pwdata[0];
               REG_STALL_WINDOW_MS:  cfg.stall_window_ms  = csr_pwdata[10:0];
               REG_STALL_MIN_COUNTS: cfg.stall_min_counts = csr_pwdata[7:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) begin
            it.kind      = req_tuser;
            it.enc_left  = req_tdata[0];
            it.enc_right = req_tdata[1];
            it.ms_tick   = req_tdata[2];
            it.target    = req_tdata[18:3];
            advance_positioner(it, next_r);
            want_q.push_back(next_r);
         end
         if (rsp_tvalid && rsp_tready) begin
            got.drive    = rsp_tdata[8:0];
            got.status   = rsp_tdata[10:9];
            got.position = rsp_tdata[26:11];
            if (want_q.size() == 0) begin
               report_mismatch("result with nothing expected", rsp_tdata, 0);
            end else begin
               want = want_q.pop_front();
               if (got.drive !== want.drive)
                  report_mismatch("drive", $signed(got.drive), $signed(want.drive));
               if (got.status !== want.status)
                  report_mismatch("status", got.status, want.status);
               if (got.position !== want.position)
                  report_mismatch("position", $signed(got.position), $signed(want.position));
               if (want.status == STATUS_REACHED) n_reached++;
               if (want.status == STATUS_STALLED) n_stalled++;
            end
            n_checked++;
         end
      end
      pending    = want_q.size();
      model_pos  = clamp_pos(count_q);
      model_busy = busy_q;
   end

endmodule

@@ tb/encoder_positioner_stall_detect_unit_tb.sv @@
module encoder_positioner_stall_detect_unit_tb;
   import epsd_pkg::*;

   // clock and the single reset at the start
   logic clock = 1'b0;
   logic reset = 1'b1;

   // req side, driven on the falling edge
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata  = '0;   // enc_left[0], enc_right[1], ms_tick[2], target[18:3], 0
   logic        req_tuser  = 1'b0; // kind[0]

   // rsp side
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;         // drive[8:0], status[10:9], position[26:11], 0

   // register port
   logic        csr_psel    = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite  = 1'b0;
   logic [3:0]  csr_paddr   = '0;
   logic [31:0] csr_pwdata  = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   // checker outputs
   int                 error_count;
   int                 pending;
   int                 n_checked;
   int                 n_reached;
   int                 n_stalled;
   logic signed [15:0] model_pos;
   logic               model_busy;

   // idle percentages for the two sides, changed per phase
   int send_idle_pct = 0;
   int rcv_idle_pct  = 30;

   // stimulus bookkeeping
   int n_sent  = 0;
   int n_live  = 0;   // words that could change state: starts and samples during a move
   int n_cfg   = 0;
   int pat_idx = 0;   // position in the quadrature pattern

   encoder_positioner_stall_detect_unit #(.POS_WIDTH(16)) dut (.*);

   epsd_motion_checker #(.POS_WIDTH(16)) u_motion_checker (.*);

   always #5 clock = ~clock;

   // receiver stalls at random, none when the percentage is zero
   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= rcv_idle_pct);
   end

   // hard stop, far beyond the slowest legal run
   initial begin
      #2_000_000;
      $display("timed out with %0d results outstanding", pending);
      $display("DONE: errors detected");
      $finish;
   end

   // one word through the req handshake; starts and ends at a falling edge
   task automatic send_word(input logic kind, input logic [1:0] lvl, input logic tick,
                            input logic signed [15:0] tgt);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      if (kind == KIND_START || model_busy) n_live++;
      n_sent++;
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      // lvl is {left, right}; left lands in bit 0
      req_tdata  <= {5'd0, tgt, tick, lvl[0], lvl[1]};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
   endtask

   // quadrature sequence: forward counts up, reverse counts down; the fifth step
   // is the sample on which the phase machine bumps the count
   function automatic logic [1:0] quad_level(bit fwd, int i);
      case (i)
         0: return fwd ? ENC_LEFT : ENC_RIGHT;
         1: return ENC_BOTH;
         2: return fwd ? ENC_RIGHT : ENC_LEFT;
         default: return ENC_NONE;
      endcase
   endfunction

   task automatic step_encoder(input bit fwd, input int tick_pct);
      logic [1:0] lvl;
      lvl = quad_level(fwd, pat_idx);
      pat_idx = (pat_idx + 1) % 5;
      send_word(KIND_SAMPLE, lvl, $urandom_range(99) < tick_pct, 16'($urandom));
   endtask

   // hold off the sender until every expected word is back, then let the
   // two pipeline stages settle
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(negedge clock);
      while (pending != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   // apb write: setup then access, then released before the next transfer
   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(negedge clock);
   endtask

   task automatic set_config(input logic [7:0] spd, input logic inv, input logic [10:0] win,
                             input logic [7:0] mn);
      wait_drained();
      csr_write(REG_DRIVE_SPEED, {24'd0, spd});
      csr_write(REG_DRIVE_INVERT, {31'd0, inv});
      csr_write(REG_STALL_WINDOW_MS, {21'd0, win});
      csr_write(REG_STALL_MIN_COUNTS, {24'd0, mn});
      n_cfg++;
   endtask

   // random settings, leaning on the extremes and on short stall windows
   task automatic pick_config();
      logic [7:0]  spd;
      logic        inv;
      logic [10:0] win;
      logic [7:0]  mn;
      case ($urandom_range(3))
         0: spd = 8'd0;
         1: spd = 8'd255;
         default: spd = 8'($urandom);
      endcase
      inv = 1'($urandom);
      case ($urandom_range(5))
         0: win = 11'd1;
         1: win = 11'd2047;
         2: win = 11'd1000;
         default: win = 11'($urandom_range(2, 12));
      endcase
      case ($urandom_range(5))
         0: mn = 8'd0;
         1: mn = 8'd255;
         default: mn = 8'($urandom_range(1, 3));
      endcase
      set_config(spd, inv, win, mn);
   endtask

   // one move: a start near the current position, then encoder samples until
   // the move ends, with some noise, wrong-way motion and cut-short moves
   task automatic run_move();
      int                 r;
      int                 tgt;
      int                 span;
      int                 cut;
      int                 tick_pct;
      int                 noise_pct;
      bit                 fwd;
      logic signed [15:0] far;
      r = $urandom_range(99);
      if (r < 8) begin
         tgt = model_pos;                      // already there
      end else if (r < 14) begin
         far = 16'($urandom);                  // any target at all
         tgt = far;
      end else begin
         tgt = int'(model_pos) + ($urandom_range(1) ? 1 : -1) * int'($urandom_range(1, 6));
      end
      if (tgt > 32767) tgt = 32767;
      if (tgt < -32768) tgt = -32768;
      fwd = (tgt >= model_pos);
      if ($urandom_range(99) < 15) fwd = !fwd;
      case ($urandom_range(3))
         0: tick_pct = 0;
         1: tick_pct = 10;
         2: tick_pct = 50;
         default: tick_pct = 100;
      endcase
      noise_pct = $urandom_range(1) ? 0 : 12;
      span = (tgt > model_pos) ? tgt - model_pos : model_pos - tgt;
      if (span > 8) span = 8;
      cut = 5 * span + 15;
      // sometimes the next start lands in the middle of this move
      if ($urandom_range(99) < 10) cut = int'($urandom_range(1, cut));
      send_word(KIND_START, 2'($urandom), 1'($urandom), 16'(tgt));
      for (int k = 0; k < cut && model_busy; k++) begin
         if ($urandom_range(99) < noise_pct)
            send_word(KIND_SAMPLE, 2'($urandom), $urandom_range(99) < tick_pct,
                      16'($urandom));
         else
            step_encoder(fwd, tick_pct);
      end
      // a stray sample now and then, while idle unless the move was cut short
      if ($urandom_range(99) < 15)
         send_word(KIND_SAMPLE, 2'($urandom), 1'($urandom), 16'($urandom));
   endtask

   initial begin : stimulus
      int live_mark;
      int cfg_mark;
      int guard;

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed part, reset settings: speed 50, no invert, window 1000, min 2
      send_word(KIND_SAMPLE, ENC_BOTH, 1'b1, 16'sh7fff);    // sample while idle
      send_word(KIND_START, ENC_NONE, 1'b0, 16'sd0);        // start already at goal
      send_word(KIND_START, ENC_NONE, 1'b1, -16'sh8000);    // downward move
      send_word(KIND_START, ENC_NONE, 1'b0, 16'sh7fff);     // restart while moving, upward
      send_word(KIND_SAMPLE, ENC_LEFT, 1'b1, 16'sd0);       // one full count up
      send_word(KIND_SAMPLE, ENC_BOTH, 1'b1, 16'sd0);
      send_word(KIND_SAMPLE, ENC_RIGHT, 1'b1, 16'sd0);
      send_word(KIND_SAMPLE, ENC_NONE, 1'b1, 16'sd0);
      send_word(KIND_SAMPLE, ENC_NONE, 1'b1, 16'sd0);
      send_word(KIND_START, ENC_NONE, 1'b0, 16'sd0);        // back down to zero
      send_word(KIND_SAMPLE, ENC_RIGHT, 1'b0, 16'sd0);
      send_word(KIND_SAMPLE, ENC_BOTH, 1'b0, 16'sd0);
      send_word(KIND_SAMPLE, ENC_LEFT, 1'b0, 16'sd0);
      send_word(KIND_SAMPLE, ENC_NONE, 1'b0, 16'sd0);
      send_word(KIND_SAMPLE, ENC_NONE, 1'b0, 16'sd0);       // reaches the goal

      // full speed inverted, shortest window, largest minimum: quick stall
      set_config(8'd255, 1'b1, 11'd1, 8'd255);
      send_word(KIND_START, ENC_NONE, 1'b0, 16'sd2);
      send_word(KIND_SAMPLE, ENC_NONE, 1'b1, 16'sd0);
      send_word(KIND_SAMPLE, ENC_NONE, 1'b1, 16'sd0);       // window exceeded, stalled
      send_word(KIND_SAMPLE, ENC_LEFT, 1'b1, 16'sd0);       // idle again

      // zero speed, stall check disabled
      set_config(8'd0, 1'b0, 11'd2047, 8'd0);
      send_word(KIND_START, ENC_NONE, 1'b0, -16'sd3);
      send_word(KIND_SAMPLE, ENC_RIGHT, 1'b1, 16'sd0);
      pat_idx = 0;

      // random phases: receiver-heavy idling, sender-heavy idling, then none
      for (int p = 0; p < 3; p++) begin
         send_idle_pct = (p == 0) ? 33 : (p == 1) ? 68 : 0;
         rcv_idle_pct  = (p == 0) ? 68 : (p == 1) ? 33 : 0;
         pick_config();
         live_mark = n_live;
         cfg_mark  = n_live;
         while (n_live - live_mark < 620) begin
            if (n_live - cfg_mark > 150) begin
               pick_config();
               cfg_mark = n_live;
            end
            run_move();
         end
      end

      // drain the last results, then let the pipeline settle
      req_tvalid <= 1'b0;
      guard = 0;
      while (pending != 0 && guard < 10000) begin
         @(negedge clock);
         guard++;
      end
      repeat (8) @(negedge clock);
      if (pending != 0) $display("%0d expected results never arrived", pending);

      $display("covered %0d words (%0d during live moves) over %0d register settings",
               n_sent, n_live, n_cfg);
      $display("%0d results compared: %0d moves reached, %0d stalled, under both stall mixes",
               n_checked, n_reached, n_stalled);
      if (error_count == 0 && pending == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

@@ files.f @@
+incdir+rtl/core
rtl/core/epsd_pkg.sv
rtl/core/epsd_calc.sv
rtl/core/encoder_positioner_stall_detect_unit.sv
tb/epsd_motion_checker.sv
tb/encoder_positioner_stall_detect_unit_tb.sv
